/* rtl/ills_pkg.sv */
// Package: shared types and constants for the indexed linked list store.
package ills_pkg;

	localparam int CAPACITY_DEF    = 1024;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int OP_W            = 3;
	localparam int POS_W           = 11;
	localparam int ITEM_W          = VALUE_WIDTH_DEF;
	localparam int STATUS_W        = 2;

	localparam logic [OP_W-1:0] OP_READ   = 3'd0;
	localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
	localparam logic [OP_W-1:0] OP_TAIL   = 3'd2;
	localparam logic [OP_W-1:0] OP_BEFORE = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic [POS_W-1:0]         position;
		logic signed [ITEM_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [ITEM_W-1:0] read_value;
	} rsp_t;

endpackage

/* rtl/indexed_linked_list_store_top.sv */
// Top level: linked list store kept in value and link memories.
//
//  channel  | handshake        | word
//  request  | start / busy     | req (operation, position, item_value)
//  response | done (strobe)    | rsp (status, read_value)
//
// A refused request is answered straight from the decide state; any other request takes
// one link-memory read per hop of the walk to a position, plus slot take, read-back and writes.
// The link memory's single read port sets the walk rate.
// done rises in the first cycle busy is low; a new word may be accepted in that cycle.
// Reset clears pointers and counts; memories stay unwritten.
// Results show on rsp with the one-cycle done strobe and stay until the next response; the receiver cannot stall.
module indexed_linked_list_store_top #(
	parameter int CAPACITY = ills_pkg::CAPACITY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ills_pkg::req_t       req,
	output logic                 done,
	output ills_pkg::rsp_t       rsp
);
	import ills_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_DECIDE = 12'b000000000010,
		S_POP    = 12'b000000000100,
		S_PLACE  = 12'b000000001000,
		S_WALK   = 12'b000000010000,
		S_MID    = 12'b000000100000,
		S_FIX    = 12'b000001000000,
		S_D0     = 12'b000010000000,
		S_D1     = 12'b000100000000,
		S_D2     = 12'b001000000000,
		S_FREE   = 12'b010000000000,
		S_RESP   = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [ITEM_W-1:0] value_mem [CAPACITY];
	logic [AW-1:0]     link_mem  [CAPACITY];

	logic [AW-1:0] head_q, tail_q, rec_head_q, cur_q, slot_q, fix_addr_q;
	logic [CW-1:0] len_q, fresh_q, rec_cnt_q, hops_q;
	logic [OP_W-1:0] op_q;
	logic [LW-1:0] pos_q, ipos_q;
	logic [ITEM_W-1:0] val_q;
	logic fwd_q;
	logic [AW-1:0] lnk_rd_q;
	logic [ITEM_W-1:0] val_rd_q;

	logic          lrd_en, lwr_en, vrd_en;
	logic [AW-1:0] lrd_addr, lwr_addr, lwr_data;

	logic [LW-1:0] len_x, ins_pos;
	logic [AW-1:0] cur_c;
	logic          pos_ok, is_ins, can_take;

	assign busy     = (state_q != S_IDLE);
	assign len_x    = LW'(len_q);
	assign cur_c    = fwd_q ? lnk_rd_q : cur_q;
	assign can_take = (rec_cnt_q != '0) || (fresh_q < CW'(CAPACITY));

	always_ff @(posedge clk) begin
		if (lwr_en) link_mem[lwr_addr] <= lwr_data;
		if (lrd_en) lnk_rd_q <= link_mem[lrd_addr];
		if (state_q == S_PLACE) value_mem[slot_q] <= val_q;
		if (vrd_en) val_rd_q <= value_mem[cur_c];
	end

	always_comb begin
		pos_ok = 1'b0; is_ins = 1'b0; ins_pos = pos_q;
		case (op_q)
			OP_READ, OP_DELETE: pos_ok = (pos_q < len_x);
			OP_HEAD: begin
				pos_ok = 1'b1; is_ins = 1'b1; ins_pos = '0;
			end
			OP_TAIL: begin
				pos_ok = 1'b1; is_ins = 1'b1; ins_pos = len_x;
			end
			OP_BEFORE: begin
				pos_ok = (pos_q <= len_x); is_ins = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		lrd_en = 1'b0; lrd_addr = cur_c;
		lwr_en = 1'b0; lwr_addr = slot_q; lwr_data = '0;
		vrd_en = 1'b0;
		case (state_q)
			S_DECIDE: begin
				if (pos_ok && is_ins && rec_cnt_q != '0) begin
					lrd_en = 1'b1; lrd_addr = rec_head_q;
				end
				if (pos_ok && op_q == OP_DELETE) begin
					lrd_en = 1'b1; lrd_addr = head_q;
				end
			end
			S_WALK: begin
				lrd_en = 1'b1;
				vrd_en = (hops_q == '0);
			end
			S_PLACE: begin
				lwr_en = 1'b1;
				if (len_q != '0 && ipos_q == '0) lwr_data = head_q;
			end
			S_MID: begin
				lwr_en = 1'b1; lwr_data = lnk_rd_q;
			end
			S_FIX: begin
				lwr_en = 1'b1; lwr_addr = fix_addr_q; lwr_data = slot_q;
			end
			S_D1: begin
				lrd_en = 1'b1; lrd_addr = lnk_rd_q;
			end
			S_D2: begin
				lwr_en = 1'b1; lwr_addr = cur_q; lwr_data = lnk_rd_q;
			end
			S_FREE: begin
				lwr_en = 1'b1; lwr_data = rec_head_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0; tail_q <= '0; rec_head_q <= '0;
			cur_q <= '0; slot_q <= '0; fix_addr_q <= '0;
			len_q <= '0; fresh_q <= '0; rec_cnt_q <= '0; hops_q <= '0;
			op_q <= '0; pos_q <= '0; ipos_q <= '0; val_q <= '0; fwd_q <= 1'b0;
			done <= 1'b0;
			rsp <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					op_q <= req.operation;
					pos_q <= LW'(req.position);
					val_q <= req.item_value;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					ipos_q <= ins_pos;
					cur_q <= head_q;
					fwd_q <= 1'b0;
					if (!pos_ok) begin
						rsp <= '{status: ST_BAD, read_value: '0};
						done <= 1'b1; state_q <= S_IDLE;
					end else if (is_ins && !can_take) begin
						rsp <= '{status: ST_FULL, read_value: '0};
						done <= 1'b1; state_q <= S_IDLE;
					end else if (is_ins) begin
						if (rec_cnt_q != '0) begin
							slot_q <= rec_head_q; state_q <= S_POP;
						end else begin
							slot_q <= fresh_q[AW-1:0];
							fresh_q <= fresh_q + 1'b1;
							state_q <= S_PLACE;
						end
					end else if (op_q == OP_READ) begin
						hops_q <= CW'(pos_q); state_q <= S_WALK;
					end else if (pos_q == '0) begin
						slot_q <= head_q; state_q <= S_D0;
					end else begin
						hops_q <= CW'(pos_q - 1'b1); state_q <= S_WALK;
					end
				end
				S_POP: begin
					rec_head_q <= lnk_rd_q;
					rec_cnt_q <= rec_cnt_q - 1'b1;
					state_q <= S_PLACE;
				end
				S_PLACE: begin
					if (len_q == '0) begin
						head_q <= slot_q; tail_q <= slot_q; len_q <= len_q + 1'b1;
						rsp <= '{status: ST_DONE, read_value: '0};
						done <= 1'b1; state_q <= S_IDLE;
					end else if (ipos_q == '0) begin
						head_q <= slot_q; len_q <= len_q + 1'b1;
						rsp <= '{status: ST_DONE, read_value: '0};
						done <= 1'b1; state_q <= S_IDLE;
					end else if (ipos_q >= len_x) begin
						fix_addr_q <= tail_q; tail_q <= slot_q; state_q <= S_FIX;
					end else begin
						hops_q <= CW'(ipos_q - 1'b1); state_q <= S_WALK;
					end
				end
				S_WALK: begin
					cur_q <= cur_c;
					if (hops_q != '0) begin
						hops_q <= hops_q - 1'b1; fwd_q <= 1'b1;
					end else begin
						fwd_q <= 1'b0;
						case (op_q)
							OP_READ: state_q <= S_RESP;
							OP_DELETE: state_q <= S_D1;
							default: state_q <= S_MID;
						endcase
					end
				end
				S_MID: begin
					fix_addr_q <= cur_q; state_q <= S_FIX;
				end
				S_FIX: begin
					len_q <= len_q + 1'b1;
					rsp <= '{status: ST_DONE, read_value: '0};
					done <= 1'b1; state_q <= S_IDLE;
				end
				S_D0: begin
					head_q <= lnk_rd_q; state_q <= S_FREE;
				end
				S_D1: begin
					slot_q <= lnk_rd_q; state_q <= S_D2;
				end
				S_D2: begin
					if (slot_q == tail_q) tail_q <= cur_q;
					state_q <= S_FREE;
				end
				S_FREE: begin
					rec_head_q <= slot_q;
					rec_cnt_q <= rec_cnt_q + 1'b1;
					len_q <= len_q - 1'b1;
					if (len_q == CW'(1)) begin
						head_q <= '0; tail_q <= '0;
					end
					rsp <= '{status: ST_DONE, read_value: '0};
					done <= 1'b1; state_q <= S_IDLE;
				end
				S_RESP: begin
					rsp <= '{status: ST_DONE, read_value: val_rd_q};
					done <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
